>>> design/bmrp_pkg.sv
// Package for the radio module response parser.
// Holds sizes, byte codes, event codes and the decode struct; no dependencies.
`default_nettype none
package bmrp_pkg;

  localparam int NAME_MAX = 21;
  localparam int CNT_W    = $clog2(NAME_MAX + 1);
  localparam int ADDR_W   = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  localparam logic [7:0] CH_O      = 8'd79;
  localparam logic [7:0] CH_K      = 8'd75;
  localparam logic [7:0] CH_N      = 8'd78;
  localparam logic [7:0] CH_Y      = 8'd89;
  localparam logic [7:0] CH_E      = 8'd69;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_BANG   = 8'd33;
  localparam logic [7:0] CH_L      = 8'd76;
  localparam logic [7:0] CH_C      = 8'd67;

  localparam logic [1:0] EV_LED_OFF    = 2'd0;
  localparam logic [1:0] EV_LED_ON     = 2'd1;
  localparam logic [1:0] EV_NAME_CHAR  = 2'd2;
  localparam logic [1:0] EV_DISCONNECT = 2'd3;

  typedef struct packed {
    logic ok_set;
    logic ok_clr;
    logic disc;
    logic led_off;
    logic led_on;
    logic cap_start;
    logic readout;
    logic store;
  } dec_t;

endpackage
`default_nettype wire

>>> design/bmrp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bmrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> design/bmrp_decode.sv
// Two-byte code decoder: judges previous and current byte against the state and the name count.
// Depends on bmrp_pkg.
`default_nettype none
module bmrp_decode (
  input  wire logic [7:0]               prev_byte,
  input  wire logic [7:0]               cur_byte,
  input  wire logic                     ok_mode,
  input  wire logic                     capture,
  input  wire logic [bmrp_pkg::CNT_W-1:0] count,
  output bmrp_pkg::dec_t                dec
);
  import bmrp_pkg::*;

  logic full;

  assign full = (count == CNT_W'(NAME_MAX));

  always_comb begin
    dec = '0;
    if (prev_byte == CH_O && cur_byte == CH_K) begin
      dec.ok_set = 1'b1;
    end else if (ok_mode) begin
      if (prev_byte == CH_L && cur_byte == CH_O) begin
        dec.ok_clr = 1'b1;
        dec.disc   = 1'b1;
      end else if (prev_byte == CH_C && cur_byte == CH_O) begin
        dec.ok_clr = 1'b1;
      end
    end else if (prev_byte == CH_N && cur_byte == CH_O) begin
      dec.led_off = 1'b1;
    end else if (prev_byte == CH_Y && cur_byte == CH_E) begin
      dec.led_on = 1'b1;
    end else if (prev_byte == CH_DOLLAR && cur_byte == CH_DOLLAR) begin
      dec.cap_start = 1'b1;
    end else if ((prev_byte == CH_BANG && cur_byte == CH_BANG) || full) begin
      dec.readout = 1'b1;
    end else if (capture && cur_byte != CH_BANG) begin
      dec.store = 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> design/ble_module_response_parser.sv
// A single-result word shows on the output in the cycle after accept; for a name readout of n
// characters the first word passes the read state and registered RAM data to the output, then
// one per cycle while out_stall is low. One input word per cycle, except while the output is held
// or a readout runs, which reads the name RAM once per character.
// Reset (synchronous, rst_n low) clears control state; the name RAM is not cleared.
// Depends on bmrp_pkg, bmrp_decode, bmrp_ram.
`default_nettype none
module ble_module_response_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_event_res,
  output logic [7:0]      out_name_char,
  output logic            out_char_valid,
  output logic            out_last
);
  import bmrp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_r, state_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic              ok_r, ok_nxt;
  logic              cap_r, cap_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] rd_last_r, rd_last_nxt;

  logic              ov_r, ov_nxt;
  logic [1:0]        oev_r, oev_nxt;
  logic [7:0]        och_r, och_nxt;
  logic              ocv_r, ocv_nxt;
  logic              olast_r, olast_nxt;

  dec_t              dec;
  logic              acc;
  logic              slot_free;
  logic              is_last;
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  bmrp_decode u_decode (
    .prev_byte (prev_r),
    .cur_byte  (in_rx_byte),
    .ok_mode   (ok_r),
    .capture   (cap_r),
    .count     (cnt_r),
    .dec       (dec)
  );

  bmrp_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign slot_free = !ov_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;
  assign acc       = in_valid && !in_stall;
  assign is_last   = (idx_r == rd_last_r);
  assign wr_en     = acc && dec.store;

  always_comb begin
    case (state_r)
      ST_READ: rd_addr = (slot_free && !is_last) ? idx_r + ADDR_W'(1) : idx_r;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    prev_nxt    = prev_r;
    ok_nxt      = ok_r;
    cap_nxt     = cap_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    rd_last_nxt = rd_last_r;
    ov_nxt      = ov_r && out_stall;
    oev_nxt     = oev_r;
    och_nxt     = och_r;
    ocv_nxt     = ocv_r;
    olast_nxt   = olast_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          prev_nxt = in_rx_byte;
          if (dec.ok_set) ok_nxt = 1'b1;
          if (dec.ok_clr) ok_nxt = 1'b0;
          if (dec.disc) begin
            cap_nxt   = 1'b0;
            cnt_nxt   = '0;
            ov_nxt    = 1'b1;
            oev_nxt   = EV_DISCONNECT;
            och_nxt   = 8'd0;
            ocv_nxt   = 1'b0;
            olast_nxt = 1'b1;
          end
          if (dec.led_off || dec.led_on) begin
            ov_nxt    = 1'b1;
            oev_nxt   = dec.led_on ? EV_LED_ON : EV_LED_OFF;
            och_nxt   = 8'd0;
            ocv_nxt   = 1'b0;
            olast_nxt = 1'b1;
          end
          if (dec.cap_start) cap_nxt = 1'b1;
          if (dec.readout) begin
            cap_nxt = 1'b0;
            cnt_nxt = '0;
            if (cnt_r == '0) begin
              ov_nxt    = 1'b1;
              oev_nxt   = EV_NAME_CHAR;
              och_nxt   = 8'd0;
              ocv_nxt   = 1'b0;
              olast_nxt = 1'b1;
            end else begin
              state_nxt   = ST_READ;
              idx_nxt     = '0;
              rd_last_nxt = ADDR_W'(cnt_r - CNT_W'(1));
            end
          end
          if (dec.store) cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_READ: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          oev_nxt   = EV_NAME_CHAR;
          och_nxt   = rd_data;
          ocv_nxt   = 1'b1;
          olast_nxt = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= '0;
      ok_r    <= 1'b0;
      cap_r   <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      ok_r    <= ok_nxt;
      cap_r   <= cap_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    rd_last_r <= rd_last_nxt;
    oev_r     <= oev_nxt;
    och_r     <= och_nxt;
    ocv_r     <= ocv_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_event_res  = oev_r;
  assign out_name_char  = och_r;
  assign out_char_valid = ocv_r;
  assign out_last       = olast_r;

endmodule
`default_nettype wire
